// ===== src/max_pool_2x2_scale_bias_defines.svh =====
// ----------------------------------------------------------------------------
// max_pool_2x2_scale_bias assertion macros
// Shared concurrent assertion forms for the pooling block.
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_2X2_SCALE_BIAS_DEFINES_SVH
`define MAX_POOL_2X2_SCALE_BIAS_DEFINES_SVH

// same-cycle implication
`define MP2_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define MP2_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== src/mp2_pkg.sv =====
// ----------------------------------------------------------------------------
// mp2_pkg
// Types and constants shared by the 2x2 max pool blocks.
// ----------------------------------------------------------------------------
package mp2_pkg;

   localparam int PIX_W       = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int SIZE_W      = 11;
   localparam int QUEUE_DEPTH = 4;

   typedef logic signed [PIX_W-1:0] pix_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAP_WIDTH     = 3'd0,
      REG_MAP_HEIGHT    = 3'd1,
      REG_SCALE         = 3'd2,
      REG_BIAS          = 3'd3,
      REG_RECORD_WINNER = 3'd4
   } reg_index_type;

   // one pixel after the front classification
   typedef struct packed {
      pix_type pixel;
      pix_type left;
      logic    odd_row;
      logic    odd_col;
      logic    last_col;
      logic    last_row;
      logic    emit;
   } front_stage_type;

   // window in scan order r0c0, r1c0, r0c1, r1c1; padding is zero
   typedef struct packed {
      pix_type [3:0] px;
      logic          row_end;
      logic          frame_end;
   } win_type;

   typedef struct packed {
      logic [PIX_W-1:0] scale;
      logic [PIX_W-1:0] bias;
      logic             record_winner;
   } back_cfg_type;

endpackage

// ===== src/mp2_ram.sv =====
// ----------------------------------------------------------------------------
// mp2_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mp2_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mp2_queue.sv =====
// ----------------------------------------------------------------------------
// mp2_queue
// Small FIFO of pooling windows between front and back.
// ----------------------------------------------------------------------------
`include "max_pool_2x2_scale_bias_defines.svh"

module mp2_queue
   import mp2_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  win_type                    push_data,
   input  logic                       pop,
   output win_type                    head,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = $clog2(DEPTH);
   localparam int QW = $clog2(DEPTH + 1);

   win_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QW-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

   `MP2_ASSERT(a_no_push_full, clock, reset, push, count_ff < QW'(DEPTH))
   `MP2_ASSERT(a_no_pop_empty, clock, reset, pop, count_ff != '0)

endmodule

// ===== src/mp2_front.sv =====
// ----------------------------------------------------------------------------
// mp2_front
// Accepts pixels, tracks raster position, keeps the line store and
// assembles each 2x2 window for the back end.
// ----------------------------------------------------------------------------
`include "max_pool_2x2_scale_bias_defines.svh"

module mp2_front
   import mp2_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int DEPTH      = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               restart,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]     map_width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]    map_height,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pix_type                            req_pixel,
   input  logic [$clog2(DEPTH+1)-1:0]         queue_count,
   output logic                               push,
   output win_type                            push_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int QW = $clog2(DEPTH + 1);

   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   pix_type         left_ff, left_in;
   pix_type         up_left_ff, up_left_in;
   logic            s_valid_ff, s_valid_in;
   front_stage_type s_ff, s_in;

   logic            accept;
   logic            last_col;
   logic            last_row;
   logic [PIX_W-1:0] rd_data;
   pix_type         above;

   // room for the item in stage B plus the new one
   assign req_stall = ({1'b0, queue_count} + (QW+1)'(s_valid_ff)) >= (QW+1)'(DEPTH);
   assign accept    = req_valid && !req_stall;

   assign last_col = (WW'(col_ff) == map_width - WW'(1));
   assign last_row = (HW'(row_ff) == map_height - HW'(1));

   // even rows fill the line store, odd rows read it back
   mp2_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept && !row_ff[0]),
      .wr_addr (col_ff),
      .wr_data (req_pixel),
      .rd_en   (accept && row_ff[0]),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      left_in    = left_ff;
      s_valid_in = accept;

      s_in.pixel    = req_pixel;
      s_in.left     = left_ff;
      s_in.odd_row  = row_ff[0];
      s_in.odd_col  = col_ff[0];
      s_in.last_col = last_col;
      s_in.last_row = last_row;
      s_in.emit     = row_ff[0] ? (col_ff[0] || last_col)
                                : (last_row && (col_ff[0] || last_col));

      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      if (accept && !col_ff[0]) begin
         left_in = req_pixel;
      end
   end

   // stage B: line store data is here now
   assign above = $signed(rd_data);

   always_comb begin
      up_left_in = up_left_ff;
      if (s_valid_ff && s_ff.odd_row && !s_ff.odd_col) begin
         up_left_in = above;
      end

      push_data.px        = '0;
      push_data.row_end   = s_ff.last_col;
      push_data.frame_end = s_ff.last_col && s_ff.last_row;
      case ({s_ff.odd_row, s_ff.odd_col})
         2'b11: begin
            push_data.px[0] = up_left_ff;
            push_data.px[1] = s_ff.left;
            push_data.px[2] = above;
            push_data.px[3] = s_ff.pixel;
         end
         2'b10: begin
            push_data.px[0] = above;
            push_data.px[1] = s_ff.pixel;
         end
         2'b01: begin
            push_data.px[0] = s_ff.left;
            push_data.px[2] = s_ff.pixel;
         end
         default: begin
            push_data.px[0] = s_ff.pixel;
         end
      endcase
   end

   assign push = s_valid_ff && s_ff.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         left_ff    <= '0;
         s_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         left_ff    <= left_in;
         s_valid_ff <= s_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff       <= s_in;
      up_left_ff <= up_left_in;
   end

   `MP2_ASSERT(a_emit_on_pair_end, clock, reset, s_valid_ff && s_ff.emit,
               s_ff.odd_col || s_ff.last_col)

endmodule

// ===== src/mp2_back.sv =====
// ----------------------------------------------------------------------------
// mp2_back
// Window maximum, scale multiply, bias, rounding and saturation.
// ----------------------------------------------------------------------------
`include "max_pool_2x2_scale_bias_defines.svh"

module mp2_back
   import mp2_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  back_cfg_type cfg,
   input  win_type      head,
   input  logic         empty,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output pix_type      rsp_pooled_value,
   output logic         rsp_winner_row,
   output logic         rsp_winner_col,
   output logic         rsp_row_end,
   output logic         rsp_frame_end
);

   // stage 1: max and winner
   logic        s1_valid_ff, s1_valid_in;
   pix_type     s1_max_ff, s1_max_in;
   logic [1:0]  s1_idx_ff, s1_idx_in;
   logic        s1_row_end_ff, s1_frame_end_ff;
   // stage 2: product
   logic               s2_valid_ff, s2_valid_in;
   logic signed [31:0] s2_prod_ff;
   logic [1:0]         s2_idx_ff;
   logic               s2_row_end_ff, s2_frame_end_ff;
   // output register
   logic        out_valid_ff, out_valid_in;
   pix_type     out_value_ff, out_value_in;
   logic        out_row_ff, out_col_ff;
   logic        out_row_end_ff, out_frame_end_ff;

   logic        out_ready, s2_ready, s1_ready;
   pix_type     a_val, b_val;
   logic        a_sel, b_sel, ab_sel;
   logic signed [33:0] sum;
   logic signed [25:0] quot;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign pop       = !empty && s1_ready;

   // first maximum wins: later entries replace only when strictly larger
   always_comb begin
      a_sel  = $signed(head.px[1]) > $signed(head.px[0]);
      a_val  = a_sel ? head.px[1] : head.px[0];
      b_sel  = $signed(head.px[3]) > $signed(head.px[2]);
      b_val  = b_sel ? head.px[3] : head.px[2];
      ab_sel = $signed(b_val) > $signed(a_val);
      s1_max_in = ab_sel ? b_val : a_val;
      s1_idx_in = ab_sel ? {1'b1, b_sel} : {1'b0, a_sel};
   end

   assign s1_valid_in  = s1_ready ? pop : s1_valid_ff;
   assign s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_ready ? s2_valid_ff : out_valid_ff;

   // Q16.16 sum, round half up, back to Q8.8
   always_comb begin
      sum  = 34'(s2_prod_ff) + $signed({{10{cfg.bias[PIX_W-1]}}, cfg.bias, 8'h00})
             + 34'sd128;
      quot = $signed(sum[33:8]);
      if (quot > 26'sd32767) begin
         out_value_in = 16'sh7fff;
      end else if (quot < -26'sd32768) begin
         out_value_in = 16'sh8000;
      end else begin
         out_value_in = $signed(quot[15:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_max_ff       <= s1_max_in;
         s1_idx_ff       <= s1_idx_in;
         s1_row_end_ff   <= head.row_end;
         s1_frame_end_ff <= head.frame_end;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_prod_ff      <= $signed(s1_max_ff) * $signed(cfg.scale);
         s2_idx_ff       <= s1_idx_ff;
         s2_row_end_ff   <= s1_row_end_ff;
         s2_frame_end_ff <= s1_frame_end_ff;
      end
      if (s2_valid_ff && out_ready) begin
         out_value_ff     <= out_value_in;
         out_row_ff       <= cfg.record_winner && s2_idx_ff[0];
         out_col_ff       <= cfg.record_winner && s2_idx_ff[1];
         out_row_end_ff   <= s2_row_end_ff;
         out_frame_end_ff <= s2_frame_end_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pooled_value = out_value_ff;
   assign rsp_winner_row   = out_row_ff;
   assign rsp_winner_col   = out_col_ff;
   assign rsp_row_end      = out_row_end_ff;
   assign rsp_frame_end    = out_frame_end_ff;

   `MP2_ASSERT(a_frame_end_is_row_end, clock, reset, rsp_valid && rsp_frame_end,
               rsp_row_end)

endmodule

// ===== src/max_pool_2x2_scale_bias.sv =====
// Windows pass stage B, the queue, back stage 1, stage 2 and the output
// register. One pixel per cycle unless req_stall is high; windows leave
// at up to one per cycle. The 4-entry window queue decouples the line
// store front from the multiply back end, so each side stalls on its own.
// Reset (synchronous): counters, valid bits and CSRs return to reset
// values; the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// max_pool_2x2_scale_bias
// 2x2 stride-2 max pooling of a raster pixel stream with Q8.8 scale and bias.
// ----------------------------------------------------------------------------
module max_pool_2x2_scale_bias
   import mp2_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration writes
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // pixel requests
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pix_type               req_pixel,
   // pooled results
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pix_type               rsp_pooled_value,
   output logic                  rsp_winner_row,
   output logic                  rsp_winner_col,
   output logic                  rsp_row_end,
   output logic                  rsp_frame_end
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int QW = $clog2(QUEUE_DEPTH + 1);

   // map size is held clamped to [1, MAX]
   logic [WW-1:0]     width_ff, width_in;
   logic [HW-1:0]     height_ff, height_in;
   logic [PIX_W-1:0]  scale_ff, scale_in;
   logic [PIX_W-1:0]  bias_ff, bias_in;
   logic              record_ff, record_in;
   logic              restart;
   logic [SIZE_W-1:0] size_raw;

   back_cfg_type      back_cfg;
   logic              push;
   win_type           push_data;
   logic              pop;
   win_type           head;
   logic              empty;
   logic [QW-1:0]     queue_count;

   assign size_raw = csr_wdata[SIZE_W-1:0];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      scale_in  = scale_ff;
      bias_in   = bias_ff;
      record_in = record_ff;
      restart   = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            REG_MAP_WIDTH: begin
               restart = 1'b1;
               if (size_raw == '0) begin
                  width_in = WW'(1);
               end else if (32'(size_raw) > MAX_WIDTH) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = WW'(size_raw);
               end
            end
            REG_MAP_HEIGHT: begin
               restart = 1'b1;
               if (size_raw == '0) begin
                  height_in = HW'(1);
               end else if (32'(size_raw) > MAX_HEIGHT) begin
                  height_in = HW'(MAX_HEIGHT);
               end else begin
                  height_in = HW'(size_raw);
               end
            end
            REG_SCALE: begin
               scale_in = csr_wdata[PIX_W-1:0];
            end
            REG_BIAS: begin
               bias_in = csr_wdata[PIX_W-1:0];
            end
            REG_RECORD_WINNER: begin
               record_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(1);
         height_ff <= HW'(1);
         scale_ff  <= 16'h0100;
         bias_ff   <= '0;
         record_ff <= 1'b1;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         scale_ff  <= scale_in;
         bias_ff   <= bias_in;
         record_ff <= record_in;
      end
   end

   assign back_cfg.scale         = scale_ff;
   assign back_cfg.bias          = bias_ff;
   assign back_cfg.record_winner = record_ff;

   // front: position tracking, line store, window assembly
   mp2_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .DEPTH      (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .map_width   (width_ff),
      .map_height  (height_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_pixel   (req_pixel),
      .queue_count (queue_count),
      .push        (push),
      .push_data   (push_data)
   );

   // window queue between front and back
   mp2_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .count     (queue_count)
   );

   // back: max, multiply, round, saturate, output register
   mp2_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (back_cfg),
      .head             (head),
      .empty            (empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pooled_value (rsp_pooled_value),
      .rsp_winner_row   (rsp_winner_row),
      .rsp_winner_col   (rsp_winner_col),
      .rsp_row_end      (rsp_row_end),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: 2x2 max pool with scale and bias
// Streams raster pixel maps into max_pool_2x2_scale_bias under random
// handshake gaps and checks every pooled result against a behavioral
// predictor: pooled value, winner position, row and frame end marks.
// ----------------------------------------------------------------------------
module tb_top;
   import mp2_pkg::*;

   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_HEIGHT    = 1024;
   localparam int DRAIN_CYCLES  = 12;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int RAND_ITEMS    = 1880;    // includes the wide and tall phases
   localparam int SQUEEZE_HOLD  = 400;     // receiver hold-off, in cycles
   localparam int CALM_LO       = 300;     // request window with no sender gaps
   localparam int CALM_HI       = 700;
   localparam int CALM_RSP_LO   = 700;     // result window with no stalls
   localparam int CALM_RSP_HI   = 900;
   localparam int N_PLAN        = 41;

   // one pooled result: value, winner row/col, row end, frame end
   typedef struct packed {
      pix_type value;
      logic    win_row;
      logic    win_col;
      logic    row_end;
      logic    frame_end;
   } pool_result_type;

   typedef enum logic {STEP_CFG, STEP_PIX} step_kind_type;

   typedef struct {
      step_kind_type   kind;
      reg_index_type   idx;     // config rows only
      logic [15:0]     data;    // register value or pixel
      logic            typed;   // want holds the result due for this pixel
      pool_result_type want;
   } step_type;

   // ------------------------------------------------------------------------
   // DUT signals, inputs at known values from time zero
   // ------------------------------------------------------------------------
   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_wr_en = 1'b0;
   reg_index_type csr_index = REG_MAP_WIDTH;
   logic [15:0]   csr_wdata = '0;
   logic          req_valid = 1'b0;
   logic          req_stall;
   pix_type       req_pixel = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   pix_type       rsp_pooled_value;
   logic          rsp_winner_row;
   logic          rsp_winner_col;
   logic          rsp_row_end;
   logic          rsp_frame_end;

   max_pool_2x2_scale_bias #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pooled_value (rsp_pooled_value),
      .rsp_winner_row   (rsp_winner_row),
      .rsp_winner_col   (rsp_winner_col),
      .rsp_row_end      (rsp_row_end),
      .rsp_frame_end    (rsp_frame_end)
   );

   // ------------------------------------------------------------------------
   // Predictor state: shadow registers, line store, left pixel, position.
   // Starts at the block's reset values.
   // ------------------------------------------------------------------------
   logic [10:0]  cfg_width  = 11'd1;
   logic [10:0]  cfg_height = 11'd1;
   pix_type      cfg_scale  = 16'sh0100;
   pix_type      cfg_bias   = '0;
   logic         cfg_record = 1'b1;
   pix_type      line_mem [MAX_WIDTH];
   pix_type      left_px = '0;
   int unsigned  col_pos = 0;
   int unsigned  row_pos = 0;

   pool_result_type owed_pools [$];   // pooled results still due from the block
   int           pixels_in  = 0;
   int           pools_out  = 0;
   int           err_count  = 0;
   int           phase_no   = 0;
   int           cycle_count = 0;
   bit           squeeze_req = 1'b0;

   // ------------------------------------------------------------------------
   // Directed requests. Typed results are the ones obvious by inspection;
   // the rest fall back on the predictor.
   // ------------------------------------------------------------------------
   step_type dir_plan [N_PLAN] = '{
      // 1x1 map after reset: the pixel itself against three padding zeros
      '{STEP_PIX, REG_MAP_WIDTH,     16'h7FFF, 1'b1, {16'h7FFF, 4'b0011}},
      // most negative pixel loses to padding at r1c0
      '{STEP_PIX, REG_MAP_WIDTH,     16'h8000, 1'b1, {16'h0000, 4'b1011}},
      // positive saturation
      '{STEP_CFG, REG_SCALE,         16'h7FFF, 1'b0, '0},
      '{STEP_CFG, REG_BIAS,          16'h7FFF, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h7FFF, 1'b1, {16'h7FFF, 4'b0011}},
      // negative saturation
      '{STEP_CFG, REG_SCALE,         16'h8000, 1'b0, '0},
      '{STEP_CFG, REG_BIAS,          16'h8000, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h7FFF, 1'b1, {16'h8000, 4'b0011}},
      // exact half rounds up
      '{STEP_CFG, REG_SCALE,         16'h0001, 1'b0, '0},
      '{STEP_CFG, REG_BIAS,          16'h0000, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h0080, 1'b1, {16'h0001, 4'b0011}},
      // winner position hidden
      '{STEP_CFG, REG_RECORD_WINNER, 16'h0000, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h8000, 1'b1, {16'h0000, 4'b0011}},
      '{STEP_CFG, REG_RECORD_WINNER, 16'h0001, 1'b0, '0},
      // zero sizes behave as 1x1
      '{STEP_CFG, REG_MAP_WIDTH,     16'h0000, 1'b0, '0},
      '{STEP_CFG, REG_MAP_HEIGHT,    16'h0000, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h0180, 1'b1, {16'h0002, 4'b0011}},
      // 2x2 maps: tie goes to r0c0, then each position wins once
      '{STEP_CFG, REG_SCALE,         16'h0100, 1'b0, '0},
      '{STEP_CFG, REG_MAP_WIDTH,     16'h0002, 1'b0, '0},
      '{STEP_CFG, REG_MAP_HEIGHT,    16'h0002, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'hFFF0, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'hFFF0, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'hFFF0, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'hFFF0, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h0001, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h0002, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h0003, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h0004, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h0001, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h0005, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h0003, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h0004, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h0001, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h0002, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h0009, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'h0004, 1'b0, '0},
      // odd width, single row: padding zeros beat negative pixels
      '{STEP_CFG, REG_MAP_WIDTH,     16'h0003, 1'b0, '0},
      '{STEP_CFG, REG_MAP_HEIGHT,    16'h0001, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'hFFFB, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'hFFFA, 1'b0, '0},
      '{STEP_PIX, REG_MAP_WIDTH,     16'hFFF9, 1'b0, '0}
   };

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   // zero means 1, anything past the limit is the limit
   function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
   endfunction

   // Advance the pooling model by one pixel. Returns 1 when the pixel closes
   // a window, with the pooled result in res.
   function automatic logic pool_pixel(input pix_type px, output pool_result_type res);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      pix_type     win [4];   // r0c0, r1c0, r0c1, r1c1
      logic        last_c;
      logic        last_r;
      logic        hit;
      int          best;
      longint      acc;

      w = clamp_dim(cfg_width, MAX_WIDTH);
      h = clamp_dim(cfg_height, MAX_HEIGHT);
      c = (col_pos >= w) ? 0 : col_pos;
      r = (row_pos >= h) ? 0 : row_pos;
      last_c = (c == w - 1);
      last_r = (r == h - 1);
      win = '{default: '0};
      hit = 1'b0;
      res = '0;

      if (r[0]) begin
         // odd row: close the window against the stored even row
         if (c[0]) begin
            win[0] = line_mem[c - 1];
            win[1] = left_px;
            win[2] = line_mem[c];
            win[3] = px;
            hit = 1'b1;
         end else if (last_c) begin
            win[0] = line_mem[c];
            win[1] = px;
            hit = 1'b1;
         end
      end else begin
         line_mem[c] = px;
         // odd height: last even row closes against a zero row
         if (last_r) begin
            if (c[0]) begin
               win[0] = left_px;
               win[2] = px;
               hit = 1'b1;
            end else if (last_c) begin
               win[0] = px;
               hit = 1'b1;
            end
         end
      end
      if (!c[0]) left_px = px;

      if (hit) begin
         best = 0;
         for (int k = 1; k < 4; k++) begin
            if (win[k] > win[best]) best = k;
         end
         // Q16.16 product plus bias, round half up, saturate
         acc = longint'(win[best]) * longint'(cfg_scale) + longint'(cfg_bias) * 256 + 128;
         acc = acc >>> 8;
         if (acc > 32767) acc = 32767;
         if (acc < -32768) acc = -32768;
         res.value     = acc[15:0];
         res.win_row   = cfg_record & best[0];
         res.win_col   = cfg_record & best[1];
         res.row_end   = last_c;
         res.frame_end = last_c & last_r;
      end

      if (last_c) begin
         col_pos = 0;
         row_pos = last_r ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
      return hit;
   endfunction

   function automatic logic [15:0] pick_size();
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return 16'd1;
         2, 3:    return 16'($urandom_range(9, 20));
         default: return 16'($urandom_range(2, 8));
      endcase
   endfunction

   // Q8.8 coefficient: the usual value, an extreme, something small or anything
   function automatic logic [15:0] pick_q88(input logic [15:0] usual);
      case ($urandom_range(7))
         0:       return usual;
         1:       return 16'h7FFF;
         2:       return 16'h8000;
         3, 4:    return 16'($urandom_range(1023)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic pix_type rand_pixel();
      case ($urandom_range(9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3:    return pix_type'($urandom_range(8) - 4);   // narrow range, many ties
         default: return pix_type'($urandom);
      endcase
   endfunction

   // queue one result at the tail of the owed list
   function automatic void owe_result(input pool_result_type r);
      owed_pools.insert(owed_pools.size(), r);
   endfunction

   task automatic flag_mismatch(input string what, input int want, input int got);
      $display("ERROR result %0d %s: expected %0h got %0h", pools_out, what, want, got);
      err_count++;
   endtask

   // ------------------------------------------------------------------------
   // Request side. Drive at the falling edge, hold until taken.
   // ------------------------------------------------------------------------
   task automatic send_pixel(input pix_type px, input logic typed,
                             input pool_result_type want);
      pool_result_type res;
      logic            hit;

      @(negedge clock);
      // random gaps, except for a long calm stretch
      while (!(pixels_in >= CALM_LO && pixels_in < CALM_HI) && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (req_stall);
      pixels_in++;
      hit = pool_pixel(px, res);
      if (typed) owe_result(want);
      else if (hit) owe_result(res);
   endtask

   // Stop offering and wait until the block has drained completely; a pixel
   // that closes no window may still be in flight after the last result.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_pools.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // One register write, mirrored into the predictor at the same edge.
   // Size writes restart the frame.
   task automatic write_reg(input reg_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_MAP_WIDTH: begin
            cfg_width = val[10:0];
            col_pos = 0;
            row_pos = 0;
         end
         REG_MAP_HEIGHT: begin
            cfg_height = val[10:0];
            col_pos = 0;
            row_pos = 0;
         end
         REG_SCALE:         cfg_scale  = val;
         REG_BIAS:          cfg_bias   = val;
         REG_RECORD_WINNER: cfg_record = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stalls, a calm window, and one long hold-off that
   // backs the block up into its request port.
   // ------------------------------------------------------------------------
   initial begin
      int hold_left = 0;
      forever begin
         @(negedge clock);
         if (squeeze_req) begin
            squeeze_req = 1'b0;
            hold_left = SQUEEZE_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (pools_out >= CALM_RSP_LO && pools_out < CALM_RSP_HI) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 26);
         end
      end
   end

   // compare each taken result with the oldest one owed
   always @(posedge clock) begin
      pool_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_pools.size() == 0) begin
            flag_mismatch("unexpected result", 0, rsp_pooled_value);
         end else begin
            want = owed_pools.pop_front();
            if (rsp_pooled_value !== want.value)
               flag_mismatch("pooled_value", want.value, rsp_pooled_value);
            if (rsp_winner_row !== want.win_row)
               flag_mismatch("winner_row", want.win_row, rsp_winner_row);
            if (rsp_winner_col !== want.win_col)
               flag_mismatch("winner_col", want.win_col, rsp_winner_col);
            if (rsp_row_end !== want.row_end)
               flag_mismatch("row_end", want.row_end, rsp_row_end);
            if (rsp_frame_end !== want.frame_end)
               flag_mismatch("frame_end", want.frame_end, rsp_frame_end);
         end
         pools_out++;
      end
   end

   // run limit
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
               owed_pools.size());
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      int n_px;
      int area;
      int rand_sent = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_plan[i]) begin
         if (dir_plan[i].kind == STEP_CFG) begin
            settle();
            write_reg(dir_plan[i].idx, dir_plan[i].data);
         end else begin
            send_pixel(pix_type'(dir_plan[i].data), dir_plan[i].typed, dir_plan[i].want);
         end
      end

      // random phases: new settings, then whole frames with random content
      while (rand_sent < RAND_ITEMS) begin
         settle();
         phase_no++;
         if (phase_no == 1) begin
            // widest map, one row; receiver holds off at the start
            write_reg(REG_MAP_WIDTH, 16'h07FF);
            write_reg(REG_MAP_HEIGHT, 16'h0001);
            squeeze_req = 1'b1;
            n_px = MAX_WIDTH;
         end else if (phase_no == 2) begin
            // oversize height, one column, broken off halfway down
            write_reg(REG_MAP_WIDTH, 16'h0001);
            write_reg(REG_MAP_HEIGHT, 16'h07FF);
            n_px = MAX_HEIGHT / 2;
         end else begin
            // now and then keep the size so a partial frame carries on
            if ($urandom_range(3) != 0) begin
               write_reg(REG_MAP_WIDTH, pick_size());
               write_reg(REG_MAP_HEIGHT, pick_size());
            end
            write_reg(REG_SCALE, pick_q88(16'h0100));
            write_reg(REG_BIAS, pick_q88(16'h0000));
            write_reg(REG_RECORD_WINNER, 16'($urandom_range(1)));
            area = clamp_dim(cfg_width, MAX_WIDTH) * clamp_dim(cfg_height, MAX_HEIGHT);
            if ($urandom_range(4) == 0)
               n_px = $urandom_range(1, 2 * area);      // broken-off frame
            else
               n_px = (area > 64) ? area : area * $urandom_range(1, 3);
            if (n_px > RAND_ITEMS - rand_sent) n_px = RAND_ITEMS - rand_sent;
         end
         repeat (n_px) send_pixel(rand_pixel(), 1'b0, '0);
         rand_sent += n_px;
      end

      settle();
      $display("Pooled %0d requests into %0d checked results over %0d setting phases",
               pixels_in, pools_out, phase_no);
      $display("Sizes from 1x1 to a full 1024-pixel row, zero and oversize settings, "
               , "coefficient extremes, winner reporting on and off");
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
